/* hdl/s256mh_pkg.sv */
`default_nettype none
package s256mh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_POS = 3'd7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

/* hdl/s256mh_if.sv */
`default_nettype none
interface s256mh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface s256mh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_position;
  logic        last_word;

  modport source (output valid, digest_word, word_position, last_word, input ready);
  modport sink (input valid, digest_word, word_position, last_word, output ready);
endinterface
`default_nettype wire

/* hdl/sha256_message_hasher.sv */
// a byte that does not close a block is taken into the block buffer in the idle state; a byte that closes a
//   block starts the load, the 64 rounds on the single round unit, and the fold
// end of message: the pad state fills each buffer byte left, over one or two blocks, then the rounds and fold
//   run per padded block, then 8 digest beats, one per cycle when out is ready
// input: no bytes are taken while a block runs its rounds and fold on the round unit
// reset: synchronous active-low rst_n restores the initial hash and clears length and fill
`default_nettype none
module sha256_message_hasher (
  input  wire             clk,
  input  wire             rst_n,
  s256mh_in_if.sink       in_ch,
  s256mh_out_if.source    out_ch
);

  s256mh_pkg::state_t state_r, state_nxt;

  logic [511:0]          blk_r;
  logic [5:0]            fill_r;
  logic [63:0]           bits_r;
  s256mh_pkg::word_t     chain_r [8];
  s256mh_pkg::word_t     a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]            rnd_r;
  logic                  fin_r;
  logic                  mark_r;
  logic                  lenhere_r;
  logic                  out_valid_r;
  s256mh_pkg::word_t     out_word_r;
  logic [2:0]            widx_r;

  logic                  in_acc;
  logic                  shift_byte;
  logic [7:0]            shift_val;
  logic [7:0]            pad_byte;
  logic [7:0]            len_byte;
  logic                  blk_full;
  logic                  load_work;
  s256mh_pkg::word_t     w0, w1, w9, w14, w_new, t1, t2;
  s256mh_pkg::word_t     fold_sum [8];

  assign in_acc = in_ch.valid && in_ch.ready;

  // schedule window taps, word j of the window sits at blk_r[511-32j -: 32]
  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];

  assign w_new = s256mh_pkg::small_sigma1(w14) + w9 + s256mh_pkg::small_sigma0(w1) + w0;
  assign t1 = h_r + s256mh_pkg::big_sigma1(e_r) + ((e_r & f_r) ^ (~e_r & g_r))
            + s256mh_pkg::ROUND_K[rnd_r] + w0;
  assign t2 = s256mh_pkg::big_sigma0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  assign fold_sum[0] = chain_r[0] + a_r;
  assign fold_sum[1] = chain_r[1] + b_r;
  assign fold_sum[2] = chain_r[2] + c_r;
  assign fold_sum[3] = chain_r[3] + d_r;
  assign fold_sum[4] = chain_r[4] + e_r;
  assign fold_sum[5] = chain_r[5] + f_r;
  assign fold_sum[6] = chain_r[6] + g_r;
  assign fold_sum[7] = chain_r[7] + h_r;

  assign len_byte = 8'(bits_r >> {3'd7 - fill_r[2:0], 3'b000});

  always_comb begin
    if (mark_r) begin
      pad_byte = s256mh_pkg::PAD_MARK;
    end else if (lenhere_r && (fill_r >= s256mh_pkg::LEN_START)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      s256mh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_present && (fill_r == s256mh_pkg::LAST_BYTE)) begin
            state_nxt = s256mh_pkg::ST_ROUND;
          end else if (in_ch.end_of_message) begin
            state_nxt = s256mh_pkg::ST_PAD;
          end
        end
      end
      s256mh_pkg::ST_PAD: begin
        if (fill_r == s256mh_pkg::LAST_BYTE) begin
          state_nxt = s256mh_pkg::ST_ROUND;
        end
      end
      s256mh_pkg::ST_ROUND: begin
        if (rnd_r == s256mh_pkg::LAST_ROUND) begin
          state_nxt = s256mh_pkg::ST_FOLD;
        end
      end
      s256mh_pkg::ST_FOLD: begin
        if (!fin_r) begin
          state_nxt = s256mh_pkg::ST_IDLE;
        end else if (lenhere_r) begin
          state_nxt = s256mh_pkg::ST_EMIT;
        end else begin
          state_nxt = s256mh_pkg::ST_PAD;
        end
      end
      s256mh_pkg::ST_EMIT: begin
        if (out_ch.ready && (widx_r == s256mh_pkg::LAST_POS)) begin
          state_nxt = s256mh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = s256mh_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    shift_byte  = 1'b0;
    shift_val   = pad_byte;
    unique case (state_r)
      s256mh_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        shift_byte  = in_acc && in_ch.byte_present;
        shift_val   = in_ch.data_byte;
      end
      s256mh_pkg::ST_PAD: begin
        shift_byte = 1'b1;
      end
      default: shift_byte = 1'b0;
    endcase
  end

  assign blk_full  = shift_byte && (fill_r == s256mh_pkg::LAST_BYTE);
  assign load_work = blk_full;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.digest_word   = out_word_r;
  assign out_ch.word_position = widx_r;
  assign out_ch.last_word     = (widx_r == s256mh_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s256mh_pkg::ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      chain_r     <= s256mh_pkg::INIT_HASH;
      rnd_r       <= '0;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenhere_r   <= 1'b0;
      out_valid_r <= 1'b0;
      widx_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (shift_byte) begin
        fill_r <= fill_r + 6'd1;
      end

      if (state_r == s256mh_pkg::ST_IDLE && in_acc) begin
        if (in_ch.byte_present) begin
          bits_r <= bits_r + s256mh_pkg::BITS_PER_BYTE;
        end
        fin_r     <= in_ch.end_of_message;
        mark_r    <= in_ch.end_of_message;
        lenhere_r <= 1'b0;
      end

      // the mark decides whether the length fits behind it in this block
      if (state_r == s256mh_pkg::ST_PAD && mark_r) begin
        mark_r    <= 1'b0;
        lenhere_r <= (fill_r < s256mh_pkg::LEN_START);
      end

      if (state_r == s256mh_pkg::ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end

      if (state_r == s256mh_pkg::ST_FOLD) begin
        chain_r <= fold_sum;
        if (fin_r && !lenhere_r && !mark_r) begin
          lenhere_r <= 1'b1;
        end
        if (fin_r && lenhere_r) begin
          out_valid_r <= 1'b1;
          widx_r      <= '0;
        end
      end

      if (state_r == s256mh_pkg::ST_EMIT && out_ch.ready) begin
        if (widx_r == s256mh_pkg::LAST_POS) begin
          out_valid_r <= 1'b0;
          widx_r      <= '0;
          chain_r     <= s256mh_pkg::INIT_HASH;
          bits_r      <= '0;
          fin_r       <= 1'b0;
          lenhere_r   <= 1'b0;
        end else begin
          widx_r <= widx_r + 3'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (shift_byte) begin
      blk_r <= {blk_r[503:0], shift_val};
    end else if (state_r == s256mh_pkg::ST_ROUND) begin
      blk_r <= {blk_r[479:0], w_new};
    end

    if (load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
      f_r <= chain_r[5];
      g_r <= chain_r[6];
      h_r <= chain_r[7];
    end else if (state_r == s256mh_pkg::ST_ROUND) begin
      h_r <= g_r;
      g_r <= f_r;
      f_r <= e_r;
      e_r <= d_r + t1;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= a_r;
      a_r <= t1 + t2;
    end

    if (state_r == s256mh_pkg::ST_FOLD) begin
      out_word_r <= fold_sum[0];
    end else if (state_r == s256mh_pkg::ST_EMIT && out_ch.ready
                 && (widx_r != s256mh_pkg::LAST_POS)) begin
      out_word_r <= chain_r[widx_r + 3'd1];
    end
  end

endmodule
`default_nettype wire

/* hdl/sha256_message_hasher_chk.sv */
`default_nettype none
module s256mh_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_digest_word,
  input wire [2:0]  out_word_position,
  input wire        out_last_word
);

  // a stalled digest beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_position))
    else $error("digest beat changed while stalled");

  // no input taken while the digest drains
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during digest output");

  // digest beats come in order without gaps
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=> out_valid
      && (out_word_position == 3'($past(out_word_position) + 3'd1)))
    else $error("digest word skipped or out of order");

  // last flag only on the final word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_position == 3'd7)))
    else $error("last flag mismatch");

  // the digest ends after its last word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid)
    else $error("digest output continued past the last word");

endmodule

bind sha256_message_hasher s256mh_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_digest_word   (out_ch.digest_word),
  .out_word_position (out_ch.word_position),
  .out_last_word     (out_ch.last_word)
);
`default_nettype wire
